// ----- src/bdcl_pkg.sv -----
package bdcl_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 4;
  localparam int unsigned MAX_LANES       = 4;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned DELAY_W         = 16;
  localparam int unsigned CFG_W           = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned IN_DATA_W       = 40;
  localparam int unsigned OUT_DATA_W      = 16;

  typedef logic [1:0] ev_code_t;
  typedef logic [1:0] rep_state_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam ev_code_t EV_PRESSED  = 2'd0;
  localparam ev_code_t EV_LONG     = 2'd1;
  localparam ev_code_t EV_CLICKED  = 2'd2;
  localparam ev_code_t EV_RELEASED = 2'd3;

  localparam rep_state_t ST_RELEASED = 2'd0;
  localparam rep_state_t ST_PRESSED  = 2'd1;
  localparam rep_state_t ST_LONG     = 2'd2;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_RESYNC = 1'b1;

  localparam cfg_idx_t CFG_ACTIVE_LOW   = 2'd0;
  localparam cfg_idx_t CFG_BUTTON_COUNT = 2'd1;
  localparam cfg_idx_t CFG_DEBOUNCE     = 2'd2;
  localparam cfg_idx_t CFG_LONG_PRESS   = 2'd3;

endpackage

// ----- src/button_debounce_click_longpress.sv -----
// Debouncer for up to four buttons with pressed, long pressed, clicked and
// released events. One input beat (a tick or a resync) is accepted per cycle
// while in_tready is high: it is registered, then all lanes are evaluated in
// one pass and the button state and the event list of the beat are committed
// together into the result buffer. The result channel sends one beat per cycle
// while out_tready is high; an input beat gives max(1, number of events) beats
// on the output (at most two per button). The next input beat is evaluated
// while the last result beat of the previous one is taken.
module button_debounce_click_longpress #(
  parameter int unsigned NUM_BUTTONS = bdcl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bdcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdcl_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] now_ms, [35:32] raw_levels, [39:36] zero
  input  logic [bdcl_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] button_index, [3:2] event_code, [11:4] state_word, [15:12] pressed_mask
  output logic [bdcl_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] event_valid
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import bdcl_pkg::*;

  localparam int unsigned NB    = NUM_BUTTONS;
  localparam int unsigned SLOTS = 2 * NB;

  logic [3:0]  alm_r;
  logic [2:0]  bcnt_r;
  logic [63:0] dd_r;
  logic [63:0] ld_r;

  logic        s1_valid_r;
  logic        s1_act_r;
  logic [31:0] s1_now_r;
  logic [3:0]  s1_raw_r;

  logic [NB-1:0] rough_r;
  logic [NB-1:0] stable_r;
  rep_state_t    rep_r [NB];
  logic [31:0]   lct_r [NB];
  logic [31:0]   pst_r [NB];

  logic [NB-1:0] rough_nxt;
  logic [NB-1:0] stable_nxt;
  rep_state_t    rep_nxt [NB];
  logic [31:0]   lct_nxt [NB];
  logic [31:0]   pst_nxt [NB];

  logic [SLOTS-1:0] ev_bits_nxt;
  ev_code_t         ev_code_nxt [SLOTS];

  logic             buf_valid_r;
  logic [SLOTS-1:0] pend_r;
  ev_code_t         code_r [SLOTS];
  logic [7:0]       word_r;
  logic [3:0]       pmask_r;

  logic [7:0] word_nxt;
  logic [3:0] pmask_nxt;
  logic [2:0] act_cnt;
  logic       load;
  logic       out_fire;
  logic       out_last;
  logic [1:0] sel_btn;
  ev_code_t   sel_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alm_r  <= '0;
      bcnt_r <= '0;
      dd_r   <= '0;
      ld_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LOW:   alm_r  <= cfg_wdata[3:0];
        CFG_BUTTON_COUNT: bcnt_r <= cfg_wdata[2:0];
        CFG_DEBOUNCE:     dd_r   <= cfg_wdata;
        CFG_LONG_PRESS:   ld_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign act_cnt   = (bcnt_r > 3'(NB)) ? 3'(NB) : bcnt_r;
  assign out_fire  = out_tvalid && out_tready;
  assign out_last  = (pend_r & (pend_r - 1'b1)) == '0;
  assign load      = s1_valid_r && (!buf_valid_r || (out_fire && out_last));
  assign in_tready = !s1_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_act_r <= in_tuser;
      s1_now_r <= in_tdata[31:0];
      s1_raw_r <= in_tdata[35:32];
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_lane
    logic       rd;
    logic       active;
    logic       chg;
    logic       deb_ok;
    logic       long_ok;
    logic       acc;
    logic [31:0] dt_chg;
    logic [31:0] dt_press;

    assign rd       = s1_raw_r[i] ^ alm_r[i];
    assign active   = 3'(i) < act_cnt;
    assign chg      = rd != rough_r[i];
    assign dt_chg   = s1_now_r - lct_r[i];
    assign dt_press = s1_now_r - pst_r[i];
    assign deb_ok   = !chg && (dt_chg > {16'd0, dd_r[16*i +: 16]});
    assign acc      = deb_ok && (rd != stable_r[i]);
    assign long_ok  = !acc && stable_r[i] && (rep_r[i] == ST_PRESSED) &&
                      (dt_press > {16'd0, ld_r[16*i +: 16]});

    always_comb begin
      rough_nxt[i]        = rough_r[i];
      stable_nxt[i]       = stable_r[i];
      rep_nxt[i]          = rep_r[i];
      lct_nxt[i]          = lct_r[i];
      pst_nxt[i]          = pst_r[i];
      ev_bits_nxt[2*i]    = 1'b0;
      ev_bits_nxt[2*i+1]  = 1'b0;
      ev_code_nxt[2*i]    = EV_PRESSED;
      ev_code_nxt[2*i+1]  = EV_RELEASED;
      if (active) begin
        if (s1_act_r == ACT_RESYNC) begin
          rough_nxt[i]  = rd;
          stable_nxt[i] = rd;
          rep_nxt[i]    = ST_RELEASED;
          lct_nxt[i]    = '0;
          pst_nxt[i]    = '0;
        end else begin
          rough_nxt[i] = rd;
          if (chg) begin
            lct_nxt[i] = s1_now_r;
          end
          if (acc) begin
            stable_nxt[i] = rd;
            if (rd) begin
              pst_nxt[i] = s1_now_r;
              rep_nxt[i] = ST_PRESSED;
              if (rep_r[i] == ST_RELEASED) begin
                ev_bits_nxt[2*i] = 1'b1;
                ev_code_nxt[2*i] = EV_PRESSED;
              end
            end else begin
              if (rep_r[i] == ST_LONG) begin
                ev_bits_nxt[2*i] = 1'b1;
                ev_code_nxt[2*i] = EV_RELEASED;
              end else if (rep_r[i] == ST_PRESSED) begin
                ev_bits_nxt[2*i]   = 1'b1;
                ev_code_nxt[2*i]   = EV_CLICKED;
                ev_bits_nxt[2*i+1] = 1'b1;
              end
              rep_nxt[i] = ST_RELEASED;
              pst_nxt[i] = '0;
            end
          end
          if (long_ok) begin
            rep_nxt[i]       = ST_LONG;
            ev_bits_nxt[2*i] = 1'b1;
            ev_code_nxt[2*i] = EV_LONG;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rough_r[i]  <= 1'b0;
        stable_r[i] <= 1'b0;
        rep_r[i]    <= ST_RELEASED;
        lct_r[i]    <= '0;
        pst_r[i]    <= '0;
      end else if (load) begin
        rough_r[i]  <= rough_nxt[i];
        stable_r[i] <= stable_nxt[i];
        rep_r[i]    <= rep_nxt[i];
        lct_r[i]    <= lct_nxt[i];
        pst_r[i]    <= pst_nxt[i];
      end
    end
  end

  always_comb begin
    word_nxt  = '0;
    pmask_nxt = '0;
    for (int i = 0; i < NB; i++) begin
      if (3'(i) < act_cnt) begin
        word_nxt[2*i +: 2] = rep_nxt[i];
        pmask_nxt[i]       = (rep_nxt[i] == ST_PRESSED) || (rep_nxt[i] == ST_LONG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      pend_r      <= '0;
    end else if (load) begin
      buf_valid_r <= 1'b1;
      pend_r      <= ev_bits_nxt;
    end else if (out_fire) begin
      if (out_last) begin
        buf_valid_r <= 1'b0;
      end
      pend_r <= pend_r & (pend_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r  <= ev_code_nxt;
      word_r  <= word_nxt;
      pmask_r <= pmask_nxt;
    end
  end

  always_comb begin
    sel_btn  = '0;
    sel_code = EV_PRESSED;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (pend_r[j]) begin
        sel_btn  = 2'(j >> 1);
        sel_code = code_r[j];
      end
    end
  end

  assign out_tvalid = buf_valid_r;
  assign out_tuser  = pend_r != '0;
  assign out_tlast  = out_last;
  assign out_tdata  = {pmask_r, word_r, sel_code, sel_btn};

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("status-only beat not marked last");

  a_more_beats: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last |=> out_tvalid && out_tuser)
    else $error("event beats lost before last");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted input beat not held");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !buf_valid_r || (out_fire && out_last))
    else $error("result buffer overwritten");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !buf_valid_r |-> pend_r == '0)
    else $error("pending events with empty buffer");

endmodule
